[src/wes_pkg.sv]
// Shared types and constants for the wheel encoder speed estimator.
`timescale 1ns / 1ps

package wes_pkg;

  localparam int WHEEL_COUNT = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int NUM_W       = 48;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int MIX_W       = 40;

  localparam logic [8:0] WEIGHT_ONE = 9'd256;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_EVAL = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_SCALE    = 2'd0,
    CFG_EMA_WEIGHT     = 2'd1,
    CFG_PAUSE_LIMIT    = 2'd2,
    CFG_TICK_INCREMENT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_NOTCH,
    KIND_EVAL,
    KIND_NOP,
    KIND_VOID
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_MIXA,
    BK_MIXB
  } bk_state_e;

  typedef struct packed {
    kind_e       kind;
    logic        wheel;
    logic [15:0] timer;
  } cmd_t;

  typedef struct packed {
    logic [31:0] speed_scale;
    logic [8:0]  ema_weight;
    logic [31:0] pause_limit;
    logic [15:0] tick_increment;
  } cfg_t;

endpackage

[src/wes_ifs.sv]
// Handshake channels for encoder events and speed results.
`timescale 1ns / 1ps

interface wes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        wheel;
  logic [15:0] timer_count;

  modport source (output valid, operation, wheel, timer_count, input ready);
  modport sink   (input valid, operation, wheel, timer_count, output ready);
endinterface

interface wes_out_if;
  logic        valid;
  logic        ready;
  logic        wheel_id;
  logic [31:0] velocity;
  logic [31:0] notch_count;
  logic        moving;

  modport source (output valid, wheel_id, velocity, notch_count, moving, input ready);
  modport sink   (input valid, wheel_id, velocity, notch_count, moving, output ready);
endinterface

[src/wes_front.sv]
// Front end: accepts events, classifies them and queues commands for the back end.
`timescale 1ns / 1ps

module wes_front (
  input  logic            clk,
  input  logic            rst_n,
  wes_in_if.sink          in_ch,
  output logic            q_valid,
  output wes_pkg::cmd_t   q_cmd,
  input  logic            q_pop
);
  import wes_pkg::*;

  cmd_t                cmd;
  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                push;
  logic                pop;

  always_comb begin
    cmd.wheel = in_ch.wheel;
    cmd.timer = in_ch.timer_count;
    if (32'(in_ch.wheel) >= WHEEL_COUNT) begin
      cmd.kind = KIND_VOID;
    end else begin
      case (op_e'(in_ch.operation))
        OP_TICK: cmd.kind = KIND_TICK;
        OP_EDGE: cmd.kind = KIND_NOTCH;
        OP_EVAL: cmd.kind = KIND_EVAL;
        default: cmd.kind = KIND_NOP;
      endcase
    end
  end

  assign in_ch.ready = (count_r != QUEUE_CW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_cmd       = mem_r[rd_ptr_r];
  assign pop         = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

[src/wes_back.sv]
// Back end: per-wheel state, serial divider, moving average and result register.
`timescale 1ns / 1ps

module wes_back (
  input  logic            clk,
  input  logic            rst_n,
  input  wes_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  wes_pkg::cmd_t   q_cmd,
  output logic            q_pop,
  wes_out_if.source       out_ch
);
  import wes_pkg::*;

  bk_state_e state_r, state_nxt;

  logic [31:0] notch_r   [WHEEL_COUNT];
  logic [31:0] seen_r    [WHEEL_COUNT];
  logic [31:0] elapsed_r [WHEEL_COUNT];
  logic [15:0] stamp_r   [WHEEL_COUNT];
  logic [31:0] avg_r     [WHEEL_COUNT];
  logic        armed_r   [WHEEL_COUNT];
  logic [31:0] notch_nxt   [WHEEL_COUNT];
  logic [31:0] seen_nxt    [WHEEL_COUNT];
  logic [31:0] elapsed_nxt [WHEEL_COUNT];
  logic [15:0] stamp_nxt   [WHEEL_COUNT];
  logic [31:0] avg_nxt     [WHEEL_COUNT];
  logic        armed_nxt   [WHEEL_COUNT];

  logic                 wheel_r, wheel_nxt;
  logic [15:0]          d_r, d_nxt;
  logic [31:0]          t_r, t_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MIX_W-1:0]     prod_r, prod_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_wheel_r, out_wheel_nxt;
  logic [31:0] out_vel_r, out_vel_nxt;
  logic [31:0] out_notch_r, out_notch_nxt;
  logic        out_moving_r, out_moving_nxt;

  logic        w;
  logic        fire;
  logic        long_eval;
  logic [31:0] diff;
  logic [15:0] d_cur;
  logic [31:0] t_raw;
  logic [32:0] tick_sum;
  logic [8:0]  wt;
  logic [32:0] div_sh;
  logic [32:0] div_sub;
  logic [31:0] q_sat;
  logic [MIX_W-1:0] mix;
  logic        load_out;
  logic        ow;

  assign w         = q_cmd.wheel;
  assign fire      = (state_r == BK_IDLE) && q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop     = fire;
  assign diff      = notch_r[w] - seen_r[w];
  assign d_cur     = diff[15:0];
  assign long_eval = (q_cmd.kind == KIND_EVAL) && (d_cur != '0) && armed_r[w];
  assign t_raw     = elapsed_r[w] + 32'(q_cmd.timer) - 32'(stamp_r[w]);
  assign tick_sum  = {1'b0, elapsed_r[w]} + 33'(cfg.tick_increment);
  assign wt        = (cfg.ema_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.ema_weight;
  assign div_sh    = {rem_r, num_r[NUM_W-1]};
  assign div_sub   = div_sh - {1'b0, t_r};
  assign q_sat     = (num_r[NUM_W-1:32] != '0) ? '1 : num_r[31:0];
  assign mix       = prod_r + MIX_W'(avg_r[wheel_r]) * MIX_W'(WEIGHT_ONE - wt);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (fire && long_eval) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == '0) state_nxt = BK_MIXA;
      BK_MIXA: state_nxt = BK_MIXB;
      BK_MIXB: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    notch_nxt   = notch_r;
    seen_nxt    = seen_r;
    elapsed_nxt = elapsed_r;
    stamp_nxt   = stamp_r;
    avg_nxt     = avg_r;
    armed_nxt   = armed_r;
    wheel_nxt   = wheel_r;
    d_nxt       = d_r;
    t_nxt       = t_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    prod_nxt    = prod_r;
    load_out    = 1'b0;
    ow          = w;

    case (state_r)
      BK_IDLE: begin
        if (fire) begin
          load_out = !long_eval;
          case (q_cmd.kind)
            KIND_TICK: begin
              if (armed_r[w]) begin
                elapsed_nxt[w] = tick_sum[32] ? '1 : tick_sum[31:0];
              end
            end
            KIND_NOTCH: notch_nxt[w] = notch_r[w] + 32'd1;
            KIND_EVAL: begin
              seen_nxt[w] = notch_r[w];
              if (d_cur != '0) begin
                stamp_nxt[w]   = q_cmd.timer;
                elapsed_nxt[w] = 32'd1;
                if (armed_r[w]) begin
                  wheel_nxt = w;
                  d_nxt     = d_cur;
                  t_nxt     = (t_raw == '0) ? 32'd1 : t_raw;
                end else begin
                  armed_nxt[w] = 1'b1;
                end
              end else if (elapsed_r[w] > cfg.pause_limit) begin
                armed_nxt[w]   = 1'b0;
                elapsed_nxt[w] = '0;
                avg_nxt[w]     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      BK_MUL: begin
        num_nxt = NUM_W'(d_r) * NUM_W'(cfg.speed_scale);
        rem_nxt = '0;
        cnt_nxt = DIV_CNT_W'(NUM_W - 1);
      end
      BK_DIV: begin
        if (!div_sub[32]) begin
          rem_nxt = div_sub[31:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[31:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end
      BK_MIXA: prod_nxt = MIX_W'(q_sat) * MIX_W'(wt);
      BK_MIXB: begin
        avg_nxt[wheel_r] = mix[MIX_W-1:8];
        load_out         = 1'b1;
        ow               = wheel_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_wheel_nxt  = out_wheel_r;
    out_vel_nxt    = out_vel_r;
    out_notch_nxt  = out_notch_r;
    out_moving_nxt = out_moving_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_wheel_nxt = ow;
      if ((state_r == BK_IDLE) && (q_cmd.kind == KIND_VOID)) begin
        out_vel_nxt    = '0;
        out_notch_nxt  = '0;
        out_moving_nxt = 1'b0;
      end else begin
        out_vel_nxt    = avg_nxt[ow];
        out_notch_nxt  = notch_nxt[ow];
        out_moving_nxt = armed_nxt[ow];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.wheel_id    = out_wheel_r;
  assign out_ch.velocity    = out_vel_r;
  assign out_ch.notch_count = out_notch_r;
  assign out_ch.moving      = out_moving_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        notch_r[i]   <= '0;
        seen_r[i]    <= '0;
        elapsed_r[i] <= '0;
        stamp_r[i]   <= '0;
        avg_r[i]     <= '0;
        armed_r[i]   <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      notch_r     <= notch_nxt;
      seen_r      <= seen_nxt;
      elapsed_r   <= elapsed_nxt;
      stamp_r     <= stamp_nxt;
      avg_r       <= avg_nxt;
      armed_r     <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wheel_r      <= wheel_nxt;
    d_r          <= d_nxt;
    t_r          <= t_nxt;
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    prod_r       <= prod_nxt;
    out_wheel_r  <= out_wheel_nxt;
    out_vel_r    <= out_vel_nxt;
    out_notch_r  <= out_notch_nxt;
    out_moving_r <= out_moving_nxt;
  end

endmodule

[src/wheel_encoder_speed_estimator.sv]
// Top level of the wheel encoder speed estimator: register file, front end and back end.
//
//   channel  direction  handshake          payload
//   in_ch    sink       valid/ready        operation[1:0] wheel timer_count[15:0]
//   out_ch   source     valid/ready        wheel_id velocity[31:0] notch_count[31:0] moving
//   cfg_*    sink       cfg_we (no wait)   cfg_idx[1:0] cfg_data[31:0]
//
// Ticks, edges and evaluates that yield no new sample are handled in the back end's idle state.
// An evaluate that yields a sample then runs the multiply, the bit-serial
// 48/32 divider (one quotient bit a cycle) and the blend steps.
// A two-item queue sits between front and back; the back end holds its next
// item while a result waits unaccepted in the result register.
// rst_n is synchronous, active low; it clears wheel state, queue and result valid.
`timescale 1ns / 1ps

module wheel_encoder_speed_estimator (
  input  logic                              clk,
  input  logic                              rst_n,
  wes_in_if.sink                            in_ch,
  wes_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [wes_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [wes_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wes_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SPEED_SCALE:    cfg_nxt.speed_scale    = cfg_data;
        CFG_EMA_WEIGHT:     cfg_nxt.ema_weight     = cfg_data[8:0];
        CFG_PAUSE_LIMIT:    cfg_nxt.pause_limit    = cfg_data;
        CFG_TICK_INCREMENT: cfg_nxt.tick_increment = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_scale    <= 32'd28160000;
      cfg_r.ema_weight     <= 9'd64;
      cfg_r.pause_limit    <= 32'd50000;
      cfg_r.tick_increment <= 16'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wes_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  wes_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[verif/wheel_encoder_speed_estimator_test.sv]
// Self-checking testbench for the wheel encoder speed estimator: directed and random events.
`timescale 1ns / 1ps

module wheel_encoder_speed_estimator_test;
  import wes_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic        wheel_id;
    logic [31:0] velocity;
    logic [31:0] notch_count;
    logic        moving;
  } reading_t;

  // Tracks both wheels and holds the readings still owed by the block.
  class speed_board;
    logic [31:0] notches [WHEEL_COUNT];
    logic [31:0] seen [WHEEL_COUNT];
    logic [31:0] elapsed [WHEEL_COUNT];
    logic [15:0] stamp [WHEEL_COUNT];
    logic [31:0] avg [WHEEL_COUNT];
    bit          armed [WHEEL_COUNT];
    logic [31:0] scale;
    logic [8:0]  weight;
    logic [31:0] pause;
    logic [15:0] tick_inc;
    reading_t    owed_readings [$];
    int          errors;

    function new();
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        notches[i] = '0;
        seen[i]    = '0;
        elapsed[i] = '0;
        stamp[i]   = '0;
        avg[i]     = '0;
        armed[i]   = 1'b0;
      end
      scale    = 32'd28160000;
      weight   = 9'd64;
      pause    = 32'd50000;
      tick_inc = 16'd1000;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_SPEED_SCALE:    scale    = val;
        CFG_EMA_WEIGHT:     weight   = val[8:0];
        CFG_PAUSE_LIMIT:    pause    = val;
        CFG_TICK_INCREMENT: tick_inc = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_readings.size();
    endfunction

    function void take_event(logic [1:0] op, logic w, logic [15:0] now);
      logic [31:0] diff;
      logic [15:0] d;
      logic [31:0] t;
      logic [63:0] sum;
      logic [63:0] q;
      logic [63:0] wt;
      logic [63:0] mix;
      reading_t    r;
      case (op)
        OP_TICK: begin
          if (armed[w]) begin
            sum = 64'(elapsed[w]) + 64'(tick_inc);
            elapsed[w] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          end
        end
        OP_EDGE: notches[w] = notches[w] + 32'd1;
        OP_EVAL: begin
          diff = notches[w] - seen[w];
          d = diff[15:0];
          seen[w] = notches[w];
          if (d != 16'd0) begin
            t = elapsed[w] + 32'(now) - 32'(stamp[w]);
            if (t == 32'd0) t = 32'd1;
            stamp[w] = now;
            elapsed[w] = 32'd1;
            if (armed[w]) begin
              q = (64'(d) * 64'(scale)) / 64'(t);
              wt = (weight > WEIGHT_ONE) ? 64'd256 : 64'(weight);
              if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
              mix = q * wt + 64'(avg[w]) * (64'd256 - wt);
              avg[w] = mix[39:8];
            end else begin
              armed[w] = 1'b1;
            end
          end else if (elapsed[w] > pause) begin
            armed[w] = 1'b0;
            elapsed[w] = 32'd0;
            avg[w] = 32'd0;
          end
        end
        default: ;
      endcase
      r.wheel_id    = w;
      r.velocity    = avg[w];
      r.notch_count = notches[w];
      r.moving      = armed[w];
      owed_readings.push_back(r);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_result(logic wid, logic [31:0] vel, logic [31:0] cnt, logic mov);
      reading_t want;
      if (owed_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual wheel %0h velocity %0h",
                 $time, wid, vel);
        return;
      end
      want = owed_readings.pop_front();
      if (want.wheel_id !== wid) report("wheel_id", 32'(want.wheel_id), 32'(wid));
      if (want.velocity !== vel) report("velocity", want.velocity, vel);
      if (want.notch_count !== cnt) report("notch_count", want.notch_count, cnt);
      if (want.moving !== mov) report("moving", 32'(want.moving), 32'(mov));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit quiet;
  logic [15:0] clock_now [WHEEL_COUNT];
  speed_board board;

  wes_in_if  in_ch ();
  wes_out_if out_ch ();

  wheel_encoder_speed_estimator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.wheel_id, out_ch.velocity, out_ch.notch_count,
                           out_ch.moving);
      if (in_ch.valid && in_ch.ready)
        board.take_event(in_ch.operation, in_ch.wheel, in_ch.timer_count);
    end
  end

  // Result side: random stall before each item.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic w, input logic [15:0] now);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.wheel       <= w;
    in_ch.timer_count <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic set_config(input logic [31:0] scale, input logic [31:0] weight,
                            input logic [31:0] pause, input logic [31:0] tick);
    logic [31:0] vals [4];
    vals[0] = scale;
    vals[1] = weight;
    vals[2] = pause;
    vals[3] = tick;
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_e'(i);
      cfg_data <= vals[i];
      board.write_reg(cfg_idx_e'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_config(input int phase);
    logic [31:0] scale;
    logic [31:0] weight;
    logic [31:0] pause;
    logic [31:0] tick;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) scale = 32'd0;
    else if (roll == 1) scale = 32'hFFFF_FFFF;
    else if (roll < 5) scale = $urandom_range(1000000, 50000000);
    else scale = $urandom;
    roll = $urandom_range(0, 9);
    if (phase == 0) weight = 32'd0;
    else if (roll == 0) weight = 32'd256;
    else if (roll == 1) weight = $urandom_range(257, 511);
    else weight = $urandom_range(0, 256);
    roll = $urandom_range(0, 9);
    if (roll == 0) pause = 32'd0;
    else if (roll == 1) pause = 32'hFFFF_FFFF;
    else if (roll < 6) pause = $urandom_range(0, 20000);
    else pause = $urandom_range(0, 200000);
    roll = $urandom_range(0, 9);
    if (roll == 0) tick = 32'd1;
    else if (roll == 1) tick = 32'd65535;
    else tick = $urandom_range(1, 5000);
    set_config(scale, weight, pause, tick);
  endtask

  // Mostly ticks and edges with evaluates read off a running timer per wheel.
  task automatic random_item();
    int roll;
    logic w;
    logic [1:0] op;
    logic [15:0] now;
    w = 1'($urandom_range(0, 1));
    clock_now[w] = clock_now[w] + 16'($urandom_range(0, 400));
    roll = $urandom_range(0, 99);
    if (roll < 45) op = OP_TICK;
    else if (roll < 75) op = OP_EDGE;
    else if (roll < 95) op = OP_EVAL;
    else op = OP_SPARE;
    if (op == OP_EVAL && $urandom_range(0, 99) < 85) now = clock_now[w];
    else now = 16'($urandom);
    send_item(op, w, now);
  endtask

  initial begin
    board = new();
    quiet = 1'b0;
    clock_now[0] = '0;
    clock_now[1] = '0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= '0;
    in_ch.wheel       <= 1'b0;
    in_ch.timer_count <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle evaluate, spare code, arming, zero elapsed time.
    send_item(OP_EVAL, 1'b0, 16'h0000);
    send_item(OP_SPARE, 1'b1, 16'hFFFF);
    send_item(OP_TICK, 1'b1, 16'h0000);
    send_item(OP_EDGE, 1'b0, 16'h0000);
    send_item(OP_EVAL, 1'b0, 16'd100);
    send_item(OP_EDGE, 1'b0, 16'h0000);
    send_item(OP_EVAL, 1'b0, 16'd99);
    send_item(OP_TICK, 1'b0, 16'hFFFF);
    send_item(OP_EDGE, 1'b0, 16'h5555);
    send_item(OP_EDGE, 1'b0, 16'hAAAA);
    send_item(OP_EDGE, 1'b0, 16'h0000);
    send_item(OP_EVAL, 1'b0, 16'hFFFF);
    drain();

    // Saturated sample at full weight, then a stop with a zero pause limit.
    set_config(32'hFFFF_FFFF, 32'd256, 32'd0, 32'd1);
    send_item(OP_EDGE, 1'b1, 16'h0000);
    send_item(OP_EVAL, 1'b1, 16'd10);
    send_item(OP_EDGE, 1'b1, 16'h0000);
    send_item(OP_EDGE, 1'b1, 16'h0000);
    send_item(OP_EVAL, 1'b1, 16'd10);
    send_item(OP_TICK, 1'b1, 16'h0000);
    send_item(OP_EVAL, 1'b1, 16'd20);
    send_item(OP_EVAL, 1'b1, 16'd30);
    drain();

    // Back-to-back run of large ticks, weight above one.
    set_config(32'd0, 32'd511, 32'hFFFF_FFFF, 32'd65535);
    send_item(OP_EDGE, 1'b0, 16'h0000);
    send_item(OP_EVAL, 1'b0, 16'd500);
    quiet = 1'b1;
    repeat (100) send_item(OP_TICK, 1'b0, 16'($urandom));
    quiet = 1'b0;
    send_item(OP_EVAL, 1'b0, 16'd600);
    send_item(OP_EDGE, 1'b0, 16'h0000);
    send_item(OP_EVAL, 1'b0, 16'd400);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_config(phase);
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (n == 125) drain();
        random_item();
      end
      quiet = 1'b0;
      drain();
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
